>>> src/bvc_pkg.sv
`timescale 1ns / 1ps

package bvc_pkg;

    // duty and full-scale width, also the number of quotient bits
    localparam int DUTY_W = 16;
    localparam int DIV_STEPS = DUTY_W;

    // full_scale / 100 by reciprocal: (fs * 83887) >> 23 is exact for 16-bit fs
    localparam int PCT_W = 10;
    localparam int RECIP_W = 17;
    localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
    localparam int RECIP_SHIFT = 23;

    localparam int NUM_LANES = 3;
    localparam int LANE_LEFT = 0;
    localparam int LANE_RIGHT = 1;
    localparam int LANE_PEDAL = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [DUTY_W-1:0] FULL_SCALE_RESET = 16'd1000;

    typedef enum logic [1:0] {
        CMD_HOLD    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_FULL    = 2'd2,
        CMD_PROP    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FULL_SCALE = 3'd0,
        REG_LEFT_MIN   = 3'd1,
        REG_LEFT_MAX   = 3'd2,
        REG_RIGHT_MIN  = 3'd3,
        REG_RIGHT_MAX  = 3'd4,
        REG_PEDAL_MIN  = 3'd5,
        REG_PEDAL_MAX  = 3'd6
    } cfg_reg_t;

    // side information that travels beside the divider cells
    typedef struct packed {
        logic                 parked;
        logic [NUM_LANES-1:0] zero_span;
        logic [DUTY_W-1:0]    full_scale;
        logic [DUTY_W-1:0]    band_lo;
        logic [DUTY_W-1:0]    band_hi;
    } ctl_t;

endpackage

>>> src/bvc_div_cell.sv
`timescale 1ns / 1ps

// one restoring division step: shift one dividend bit in, subtract if it fits
module bvc_div_cell #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [SAMPLE_BITS-1:0]      rem_in,
    input  logic [bvc_pkg::DUTY_W-1:0]  word_in,
    input  logic [SAMPLE_BITS-1:0]      div_in,
    output logic [SAMPLE_BITS-1:0]      rem_out,
    output logic [bvc_pkg::DUTY_W-1:0]  word_out,
    output logic [SAMPLE_BITS-1:0]      div_out
);
    import bvc_pkg::*;

    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   diff;
    logic                   fits;
    logic [SAMPLE_BITS-1:0] rem_next;
    logic [DUTY_W-1:0]      word_next;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [DUTY_W-1:0]      word_reg;
    logic [SAMPLE_BITS-1:0] div_reg;

    always_comb
    begin
        trial     = {rem_in, word_in[DUTY_W-1]};
        diff      = trial - {1'b0, div_in};
        fits      = trial >= {1'b0, div_in};
        rem_next  = fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
        // quotient bits enter at the bottom as dividend bits leave the top
        word_next = {word_in[DUTY_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
            div_reg  <= div_in;
        end
    end

    assign rem_out  = rem_reg;
    assign word_out = word_reg;
    assign div_out  = div_reg;

endmodule

>>> src/bvc_side.sv
`timescale 1ns / 1ps

// fill and steering-brake valve choice for one side
module bvc_side (
    input  logic [bvc_pkg::DUTY_W-1:0] lever,
    input  logic [bvc_pkg::DUTY_W-1:0] pedal,
    input  logic [bvc_pkg::DUTY_W-1:0] full_scale,
    input  logic [bvc_pkg::DUTY_W-1:0] band_lo,
    input  logic [bvc_pkg::DUTY_W-1:0] band_hi,
    output bvc_pkg::cmd_t              fill_cmd,
    output logic [bvc_pkg::DUTY_W-1:0] fill_duty,
    output bvc_pkg::cmd_t              steer_cmd,
    output logic [bvc_pkg::DUTY_W-1:0] steer_duty
);
    import bvc_pkg::*;

    logic [DUTY_W:0] lever_x2;

    assign lever_x2 = {lever, 1'b0};

    always_comb
    begin
        priority if (lever <= band_lo)
        begin
            fill_cmd  = CMD_FULL;
            fill_duty = '0;
        end
        else if (lever_x2 < {1'b0, full_scale})
        begin
            fill_cmd  = CMD_PROP;
            fill_duty = lever_x2[DUTY_W-1:0];
        end
        else
        begin
            fill_cmd  = CMD_RELEASE;
            fill_duty = '0;
        end
    end

    // the control that brakes harder wins
    always_comb
    begin
        priority if (lever <= band_lo && pedal <= band_lo)
        begin
            steer_cmd  = CMD_RELEASE;
            steer_duty = '0;
        end
        else if (pedal < band_hi && pedal >= lever)
        begin
            steer_cmd  = CMD_PROP;
            steer_duty = pedal;
        end
        else if (lever < band_hi && pedal < lever)
        begin
            steer_cmd  = CMD_PROP;
            steer_duty = lever;
        end
        else
        begin
            steer_cmd  = CMD_FULL;
            steer_duty = '0;
        end
    end

endmodule

>>> src/brake_valve_command.sv
`timescale 1ns / 1ps

// Brake valve command. Takes one set of lever and pedal samples per transfer and
// returns one set of four valve commands with duties per transfer, in order. A new
// sample set is taken every cycle unless a stalled result holds the pipeline; each
// result passes through the clamp-and-offset register, the span product and band
// register, the row of divider cells that makes one quotient bit each, and the valve
// choice in the output register. The divider row holds sixteen sets in flight. The
// whole pipeline halts only while a finished result sits in the output register
// under stall. Configuration writes are always taken (cfg_ready is tied high) and
// must only be issued while idle.
module brake_valve_command #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [SAMPLE_BITS-1:0]              left_sample,
    input  logic [SAMPLE_BITS-1:0]              right_sample,
    input  logic [SAMPLE_BITS-1:0]              pedal_sample,
    input  logic                                parked,
    // command channel
    output logic                                cmd_valid,
    input  logic                                cmd_stall,
    output logic [1:0]                          fill_left_cmd,
    output logic [bvc_pkg::DUTY_W-1:0]          fill_left_duty,
    output logic [1:0]                          steer_left_cmd,
    output logic [bvc_pkg::DUTY_W-1:0]          steer_left_duty,
    output logic [1:0]                          fill_right_cmd,
    output logic [bvc_pkg::DUTY_W-1:0]          fill_right_duty,
    output logic [1:0]                          steer_right_cmd,
    output logic [bvc_pkg::DUTY_W-1:0]          steer_right_duty,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bvc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bvc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bvc_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PROD_W = SB + DUTY_W;
    localparam int PCT_PROD_W = DUTY_W + RECIP_W;
    // released-position limit after reset, cut to the sample width
    localparam logic [SB-1:0] LIMIT_MAX_RESET = SB'(32'd4095);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [DUTY_W-1:0] full_scale_reg;
    logic [SB-1:0]     left_min_reg, left_max_reg;
    logic [SB-1:0]     right_min_reg, right_max_reg;
    logic [SB-1:0]     pedal_min_reg, pedal_max_reg;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= FULL_SCALE_RESET;
            left_min_reg   <= '0;
            left_max_reg   <= LIMIT_MAX_RESET;
            right_min_reg  <= '0;
            right_max_reg  <= LIMIT_MAX_RESET;
            pedal_min_reg  <= '0;
            pedal_max_reg  <= LIMIT_MAX_RESET;
        end
        else if (cfg_write)
        begin
            // an index past the register list is dropped
            unique case (cfg_reg_t'(cfg_index))
                REG_FULL_SCALE: full_scale_reg <= cfg_data;
                REG_LEFT_MIN:   left_min_reg   <= cfg_data[SB-1:0];
                REG_LEFT_MAX:   left_max_reg   <= cfg_data[SB-1:0];
                REG_RIGHT_MIN:  right_min_reg  <= cfg_data[SB-1:0];
                REG_RIGHT_MAX:  right_max_reg  <= cfg_data[SB-1:0];
                REG_PEDAL_MIN:  pedal_min_reg  <= cfg_data[SB-1:0];
                REG_PEDAL_MAX:  pedal_max_reg  <= cfg_data[SB-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // flow control: every stage moves together unless the output
    // register holds a result that is not being taken
    // ---------------------------------------------------------------
    logic cmd_valid_reg;
    logic advance;

    assign advance      = !(cmd_valid_reg && cmd_stall);
    assign sample_stall = !advance;
    assign cmd_valid    = cmd_valid_reg;

    // ---------------------------------------------------------------
    // stage 0: clamp each sample into its limits and take the offset
    // ---------------------------------------------------------------
    logic [SB-1:0] lane_sample [NUM_LANES];
    logic [SB-1:0] lane_lo     [NUM_LANES];
    logic [SB-1:0] lane_hi     [NUM_LANES];
    logic [SB-1:0] lane_off    [NUM_LANES];
    logic [SB-1:0] lane_span   [NUM_LANES];
    logic [NUM_LANES-1:0] lane_zero;

    assign lane_sample[LANE_LEFT]  = left_sample;
    assign lane_sample[LANE_RIGHT] = right_sample;
    assign lane_sample[LANE_PEDAL] = pedal_sample;
    assign lane_lo[LANE_LEFT]      = left_min_reg;
    assign lane_lo[LANE_RIGHT]     = right_min_reg;
    assign lane_lo[LANE_PEDAL]     = pedal_min_reg;
    assign lane_hi[LANE_LEFT]      = left_max_reg;
    assign lane_hi[LANE_RIGHT]     = right_max_reg;
    assign lane_hi[LANE_PEDAL]     = pedal_max_reg;

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_offset
        logic [SB-1:0] clamped;

        always_comb
        begin
            // zero or inverted span reads as offset zero
            lane_zero[k] = lane_hi[k] <= lane_lo[k];
            priority if (lane_sample[k] < lane_lo[k])
                clamped = lane_lo[k];
            else if (lane_sample[k] > lane_hi[k])
                clamped = lane_hi[k];
            else
                clamped = lane_sample[k];
            lane_off[k]  = lane_zero[k] ? '0 : clamped - lane_lo[k];
            lane_span[k] = lane_hi[k] - lane_lo[k];
        end
    end

    // full_scale / 100 through the reciprocal
    logic [PCT_PROD_W-1:0] pct_prod;

    assign pct_prod = PCT_PROD_W'(full_scale_reg) * PCT_PROD_W'(RECIP_100);

    logic                 s0_valid_reg;
    logic                 s0_parked_reg;
    logic [NUM_LANES-1:0] s0_zero_reg;
    logic [DUTY_W-1:0]    s0_fs_reg;
    logic [PCT_W-1:0]     s0_pct_reg;
    logic [SB-1:0]        s0_off_reg  [NUM_LANES];
    logic [SB-1:0]        s0_span_reg [NUM_LANES];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_parked_reg <= parked;
            s0_zero_reg   <= lane_zero;
            s0_fs_reg     <= full_scale_reg;
            s0_pct_reg    <= pct_prod[RECIP_SHIFT +: PCT_W];
            for (int k = 0; k < NUM_LANES; k++)
            begin
                s0_off_reg[k]  <= lane_off[k];
                s0_span_reg[k] <= lane_span[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: offset times full scale, and the 5% / 95% bands
    // ---------------------------------------------------------------
    logic [DUTY_W-1:0] band_lo_next;
    logic [DUTY_W-1:0] band_hi_next;
    ctl_t              s1_ctl_next;

    assign band_lo_next = DUTY_W'(s0_pct_reg) * DUTY_W'(5);
    assign band_hi_next = DUTY_W'(s0_pct_reg) * DUTY_W'(95);

    always_comb
    begin
        s1_ctl_next.parked     = s0_parked_reg;
        s1_ctl_next.zero_span  = s0_zero_reg;
        s1_ctl_next.full_scale = s0_fs_reg;
        s1_ctl_next.band_lo    = band_lo_next;
        s1_ctl_next.band_hi    = band_hi_next;
    end

    logic          s1_valid_reg;
    ctl_t          s1_ctl_reg;
    logic [PROD_W-1:0] s1_prod_reg [NUM_LANES];
    logic [SB-1:0]     s1_span_reg [NUM_LANES];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg <= s1_ctl_next;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                s1_prod_reg[k] <= PROD_W'(s0_off_reg[k]) * PROD_W'(s0_fs_reg);
                s1_span_reg[k] <= s0_span_reg[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // divider row: one quotient bit per cell, three lanes side by side.
    // for a nonzero span the product never reaches span << 16, so its top part starts as
    // a remainder already below the span
    // ---------------------------------------------------------------
    logic [SB-1:0]     rem_chain  [NUM_LANES][DIV_STEPS+1];
    logic [DUTY_W-1:0] word_chain [NUM_LANES][DIV_STEPS+1];
    logic [SB-1:0]     div_chain  [NUM_LANES][DIV_STEPS+1];

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        assign rem_chain[k][0]  = s1_prod_reg[k][PROD_W-1:DUTY_W];
        assign word_chain[k][0] = s1_prod_reg[k][DUTY_W-1:0];
        assign div_chain[k][0]  = s1_span_reg[k];

        for (genvar j = 0; j < DIV_STEPS; j++)
        begin : g_cell
            bvc_div_cell #(
                .SAMPLE_BITS (SB)
            ) u_cell (
                .clk      (clk),
                .en       (advance),
                .rem_in   (rem_chain[k][j]),
                .word_in  (word_chain[k][j]),
                .div_in   (div_chain[k][j]),
                .rem_out  (rem_chain[k][j+1]),
                .word_out (word_chain[k][j+1]),
                .div_out  (div_chain[k][j+1])
            );
        end
    end

    // side information keeps step with the cells
    logic [DIV_STEPS-1:0] cell_valid_reg;
    ctl_t                 ctl_pipe_reg [DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_pipe_reg[0] <= s1_ctl_reg;
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                ctl_pipe_reg[j] <= ctl_pipe_reg[j-1];
            end
        end
    end

    // valid bits of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            cell_valid_reg <= '0;
            cmd_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg   <= sample_valid;
            s1_valid_reg   <= s0_valid_reg;
            cell_valid_reg <= {cell_valid_reg[DIV_STEPS-2:0], s1_valid_reg};
            cmd_valid_reg  <= cell_valid_reg[DIV_STEPS-1];
        end
    end

    // ---------------------------------------------------------------
    // valve choice: levers are inverted, the pedal is direct
    // ---------------------------------------------------------------
    ctl_t              ctl_last;
    logic [DUTY_W-1:0] scaled [NUM_LANES];
    logic [DUTY_W-1:0] lever_left;
    logic [DUTY_W-1:0] lever_right;

    assign ctl_last = ctl_pipe_reg[DIV_STEPS-1];

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_scaled
        assign scaled[k] = ctl_last.zero_span[k] ? '0 : word_chain[k][DIV_STEPS];
    end

    assign lever_left  = ctl_last.full_scale - scaled[LANE_LEFT];
    assign lever_right = ctl_last.full_scale - scaled[LANE_RIGHT];

    cmd_t              fl_cmd, sl_cmd, fr_cmd, sr_cmd;
    logic [DUTY_W-1:0] fl_duty, sl_duty, fr_duty, sr_duty;

    bvc_side u_side_left (
        .lever      (lever_left),
        .pedal      (scaled[LANE_PEDAL]),
        .full_scale (ctl_last.full_scale),
        .band_lo    (ctl_last.band_lo),
        .band_hi    (ctl_last.band_hi),
        .fill_cmd   (fl_cmd),
        .fill_duty  (fl_duty),
        .steer_cmd  (sl_cmd),
        .steer_duty (sl_duty)
    );

    bvc_side u_side_right (
        .lever      (lever_right),
        .pedal      (scaled[LANE_PEDAL]),
        .full_scale (ctl_last.full_scale),
        .band_lo    (ctl_last.band_lo),
        .band_hi    (ctl_last.band_hi),
        .fill_cmd   (fr_cmd),
        .fill_duty  (fr_duty),
        .steer_cmd  (sr_cmd),
        .steer_duty (sr_duty)
    );

    // ---------------------------------------------------------------
    // output register: parked forces every valve to hold
    // ---------------------------------------------------------------
    cmd_t              fill_left_cmd_reg, steer_left_cmd_reg;
    cmd_t              fill_right_cmd_reg, steer_right_cmd_reg;
    logic [DUTY_W-1:0] fill_left_duty_reg, steer_left_duty_reg;
    logic [DUTY_W-1:0] fill_right_duty_reg, steer_right_duty_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (ctl_last.parked)
            begin
                fill_left_cmd_reg    <= CMD_HOLD;
                steer_left_cmd_reg   <= CMD_HOLD;
                fill_right_cmd_reg   <= CMD_HOLD;
                steer_right_cmd_reg  <= CMD_HOLD;
                fill_left_duty_reg   <= '0;
                steer_left_duty_reg  <= '0;
                fill_right_duty_reg  <= '0;
                steer_right_duty_reg <= '0;
            end
            else
            begin
                fill_left_cmd_reg    <= fl_cmd;
                steer_left_cmd_reg   <= sl_cmd;
                fill_right_cmd_reg   <= fr_cmd;
                steer_right_cmd_reg  <= sr_cmd;
                fill_left_duty_reg   <= fl_duty;
                steer_left_duty_reg  <= sl_duty;
                fill_right_duty_reg  <= fr_duty;
                steer_right_duty_reg <= sr_duty;
            end
        end
    end

    assign fill_left_cmd    = fill_left_cmd_reg;
    assign steer_left_cmd   = steer_left_cmd_reg;
    assign fill_right_cmd   = fill_right_cmd_reg;
    assign steer_right_cmd  = steer_right_cmd_reg;
    assign fill_left_duty   = fill_left_duty_reg;
    assign steer_left_duty  = steer_left_duty_reg;
    assign fill_right_duty  = fill_right_duty_reg;
    assign steer_right_duty = steer_right_duty_reg;

endmodule

>>> src/bvc_checker.sv
`timescale 1ns / 1ps

module bvc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_stall,
    input logic [1:0]                 fill_left_cmd,
    input logic [bvc_pkg::DUTY_W-1:0] fill_left_duty,
    input logic [1:0]                 steer_left_cmd,
    input logic [bvc_pkg::DUTY_W-1:0] steer_left_duty,
    input logic [1:0]                 fill_right_cmd,
    input logic [bvc_pkg::DUTY_W-1:0] fill_right_duty,
    input logic [1:0]                 steer_right_cmd,
    input logic [bvc_pkg::DUTY_W-1:0] steer_right_duty
);
    import bvc_pkg::*;

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(fill_left_cmd)
            && $stable(steer_left_duty) && $stable(fill_right_duty)
            && $stable(steer_right_cmd))
        else $error("result changed while stalled");

    // hold comes only from parking, and then on every valve
    a_hold_all: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (fill_left_cmd == CMD_HOLD || steer_right_cmd == CMD_HOLD)
            |-> fill_left_cmd == CMD_HOLD && steer_left_cmd == CMD_HOLD
                && fill_right_cmd == CMD_HOLD && steer_right_cmd == CMD_HOLD
                && fill_left_duty == '0 && steer_right_duty == '0)
        else $error("partial hold");

    // a proportional fill duty is twice a lever value above the low band
    a_fill_duty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (fill_left_cmd == CMD_PROP || fill_right_cmd == CMD_PROP)
            |-> (fill_left_cmd != CMD_PROP
                    || (fill_left_duty[0] == 1'b0 && fill_left_duty != '0))
                && (fill_right_cmd != CMD_PROP
                    || (fill_right_duty[0] == 1'b0 && fill_right_duty != '0)))
        else $error("bad proportional fill duty");

    // a duty only comes with a proportional command
    a_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (fill_left_cmd == CMD_PROP || fill_left_duty == '0)
            && (steer_left_cmd == CMD_PROP || steer_left_duty == '0)
            && (fill_right_cmd == CMD_PROP || fill_right_duty == '0)
            && (steer_right_cmd == CMD_PROP || steer_right_duty == '0))
        else $error("duty without proportional command");

endmodule

bind brake_valve_command bvc_checker u_bvc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd_stall        (cmd_stall),
    .fill_left_cmd    (fill_left_cmd),
    .fill_left_duty   (fill_left_duty),
    .steer_left_cmd   (steer_left_cmd),
    .steer_left_duty  (steer_left_duty),
    .fill_right_cmd   (fill_right_cmd),
    .fill_right_duty  (fill_right_duty),
    .steer_right_cmd  (steer_right_cmd),
    .steer_right_duty (steer_right_duty)
);
